// ===== rtl/fcw_pkg.sv =====
// Shared types and constants for the FAT12 cluster chain walker.
// No dependencies; used by every module of the block.
`default_nettype none

package fcw_pkg;

    localparam int TABLE_ENTRIES = 4096;
    localparam int CL_W          = 12;   // cluster / hop count width
    localparam int ADDR_W        = 13;   // byte address width
    localparam int DATA_W        = 8;    // table byte width

    // result status codes
    localparam logic [1:0] ST_OK  = 2'd0;
    localparam logic [1:0] ST_END = 2'd1;
    localparam logic [1:0] ST_BAD = 2'd2;

    // entry value bounds
    localparam logic [CL_W-1:0] ENT_RSVD = 12'hFF0;
    localparam logic [CL_W-1:0] ENT_EOC  = 12'hFF8;

    typedef struct packed {
        logic              cmd;
        logic [ADDR_W-1:0] byte_addr;
        logic [DATA_W-1:0] byte_data;
        logic [CL_W-1:0]   first_cluster;
        logic [CL_W-1:0]   hop_count;
    } t_in_item;

    typedef struct packed {
        logic [1:0]      status;
        logic [CL_W-1:0] cluster;
    } t_out_item;

    // classification of one unpacked entry
    typedef enum logic [1:0] {
        K_ADV = 2'd0,
        K_END = 2'd1,
        K_BAD = 2'd2
    } t_kind;

    // where the result cluster comes from
    typedef enum logic [1:0] {
        SRC_ZERO  = 2'd0,
        SRC_FIRST = 2'd1,
        SRC_ENTRY = 2'd2
    } t_res_src;

    typedef struct packed {
        logic       accept;
        logic       rd_lo;
        logic       rd_hi;
        logic       advance;
        logic       res_load;
        logic [1:0] res_status;
        t_res_src   res_src;
    } t_dp_cmd;

    typedef struct packed {
        logic  in_walk;
        logic  in_hops_zero;
        logic  cur_oob;
        t_kind kind;
        logic  last_hop;
    } t_dp_stat;

endpackage

`default_nettype wire

// ===== rtl/fcw_datapath.sv =====
// Datapath: table byte store, walk registers, entry unpack and result register.
// Depends on fcw_pkg.
`default_nettype none

module fcw_datapath #(
    parameter int TABLE_ENTRIES = fcw_pkg::TABLE_ENTRIES
) (
    input  wire                 i_clk,
    input  wire fcw_pkg::t_in_item  i_in,
    input  wire fcw_pkg::t_dp_cmd   i_cmd,
    output fcw_pkg::t_dp_stat       o_stat,
    output fcw_pkg::t_out_item      o_out
);

    localparam int TABLE_BYTES = (TABLE_ENTRIES * 3) / 2;
    localparam int MAW         = $clog2(TABLE_BYTES);

    logic [fcw_pkg::DATA_W-1:0] r_mem [TABLE_BYTES];
    logic [fcw_pkg::DATA_W-1:0] r_rd_data;
    logic                       r_rd_oob;
    logic [fcw_pkg::DATA_W-1:0] r_lo;
    logic [fcw_pkg::CL_W-1:0]   r_cur;
    logic [fcw_pkg::CL_W-1:0]   r_hops;
    fcw_pkg::t_out_item         r_out;

    logic [fcw_pkg::ADDR_W-1:0] base;
    logic [fcw_pkg::ADDR_W-1:0] rd_addr;
    logic                       wr_en;
    logic [fcw_pkg::DATA_W-1:0] hi;
    logic [fcw_pkg::CL_W-1:0]   entry;
    fcw_pkg::t_kind             kind;
    logic [fcw_pkg::CL_W-1:0]   res_cluster;

    // byte offset of the entry: c*3/2 = c + c/2
    assign base    = fcw_pkg::ADDR_W'(r_cur) + fcw_pkg::ADDR_W'(r_cur[fcw_pkg::CL_W-1:1]);
    assign rd_addr = i_cmd.rd_hi ? base + fcw_pkg::ADDR_W'(1) : base;
    assign wr_en   = i_cmd.accept && !i_in.cmd
                     && (i_in.byte_addr < fcw_pkg::ADDR_W'(TABLE_BYTES));

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[i_in.byte_addr[MAW-1:0]] <= i_in.byte_data;
        end
        if (i_cmd.rd_lo || i_cmd.rd_hi) begin
            r_rd_data <= r_mem[rd_addr[MAW-1:0]];
            r_rd_oob  <= rd_addr >= fcw_pkg::ADDR_W'(TABLE_BYTES);
        end
    end

    assign hi = r_rd_oob ? '0 : r_rd_data;

    always_comb begin
        if (r_cur[0]) begin
            entry = {hi, r_lo[7:4]};
        end else begin
            entry = {hi[3:0], r_lo};
        end
        if (entry != '0 && entry < fcw_pkg::ENT_RSVD) begin
            kind = fcw_pkg::K_ADV;
        end else if (entry >= fcw_pkg::ENT_EOC) begin
            kind = fcw_pkg::K_END;
        end else begin
            kind = fcw_pkg::K_BAD;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_cur  <= i_in.first_cluster;
            r_hops <= i_in.hop_count;
        end else if (i_cmd.advance) begin
            r_cur  <= entry;
            r_hops <= r_hops - fcw_pkg::CL_W'(1);
        end
        if (i_cmd.rd_hi) begin
            r_lo <= hi;     // low byte read was issued the cycle before
        end
    end

    always_comb begin
        unique case (i_cmd.res_src)
            fcw_pkg::SRC_FIRST: res_cluster = i_in.first_cluster;
            fcw_pkg::SRC_ENTRY: res_cluster = entry;
            default:            res_cluster = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.res_load) begin
            r_out.status  <= i_cmd.res_status;
            r_out.cluster <= res_cluster;
        end
    end

    assign o_stat.in_walk      = i_in.cmd;
    assign o_stat.in_hops_zero = (i_in.hop_count == '0);
    assign o_stat.cur_oob      = {1'b0, r_cur} >= (fcw_pkg::CL_W + 1)'(TABLE_ENTRIES);
    assign o_stat.kind         = kind;
    assign o_stat.last_hop     = (r_hops == fcw_pkg::CL_W'(1));
    assign o_out               = r_out;

endmodule

`default_nettype wire

// ===== rtl/fcw_ctrl.sv =====
// Controller: walk sequencer and handshake control for both channels.
// Depends on fcw_pkg.
`default_nettype none

module fcw_ctrl (
    input  wire                     i_clk,
    input  wire                     i_rst_n,
    input  wire                     i_in_valid,
    output logic                    o_in_ready,
    output logic                    o_out_valid,
    input  wire                     i_out_ready,
    input  wire fcw_pkg::t_dp_stat  i_stat,
    output fcw_pkg::t_dp_cmd        o_cmd
);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_LO   = 4'b0010,
        S_HI   = 4'b0100,
        S_EVAL = 4'b1000
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   accept;

    assign o_in_ready = (r_state == S_IDLE) && (!r_out_valid || i_out_ready);
    assign accept     = i_in_valid && o_in_ready;

    always_comb begin
        n_state          = r_state;
        o_cmd            = '0;
        o_cmd.accept     = accept;
        o_cmd.res_status = fcw_pkg::ST_OK;
        o_cmd.res_src    = fcw_pkg::SRC_ZERO;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    if (i_stat.in_walk && !i_stat.in_hops_zero) begin
                        n_state = S_LO;
                    end else begin
                        o_cmd.res_load = 1'b1;
                        o_cmd.res_src  = i_stat.in_walk ? fcw_pkg::SRC_FIRST
                                                        : fcw_pkg::SRC_ZERO;
                    end
                end
            end
            S_LO: begin
                if (i_stat.cur_oob) begin
                    o_cmd.res_load   = 1'b1;
                    o_cmd.res_status = fcw_pkg::ST_BAD;
                    n_state          = S_IDLE;
                end else begin
                    o_cmd.rd_lo = 1'b1;
                    n_state     = S_HI;
                end
            end
            S_HI: begin
                o_cmd.rd_hi = 1'b1;
                n_state     = S_EVAL;
            end
            S_EVAL: begin
                unique case (i_stat.kind)
                    fcw_pkg::K_ADV: begin
                        o_cmd.advance = 1'b1;
                        if (i_stat.last_hop) begin
                            o_cmd.res_load = 1'b1;
                            o_cmd.res_src  = fcw_pkg::SRC_ENTRY;
                            n_state        = S_IDLE;
                        end else begin
                            n_state = S_LO;
                        end
                    end
                    fcw_pkg::K_END: begin
                        o_cmd.res_load   = 1'b1;
                        o_cmd.res_status = fcw_pkg::ST_END;
                        n_state          = S_IDLE;
                    end
                    default: begin
                        o_cmd.res_load   = 1'b1;
                        o_cmd.res_status = fcw_pkg::ST_BAD;
                        n_state          = S_IDLE;
                    end
                endcase
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end
        if (o_cmd.res_load) begin
            n_out_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

`default_nettype wire

// ===== rtl/fat12_cluster_chain_walker_core.sv =====
// A write or a zero-hop walk gives its result in the cycle after acceptance. Each
// hop of a walk checks the cluster and reads the low byte, reads the high byte,
// then classifies the entry; the single-port table store gives one byte per cycle.
// One item is in flight at a time; the next is taken once the walk has finished.
// Reset clears the sequencer and output valid; the table is undefined until written.
`default_nettype none

// Top level of the FAT12 cluster chain walker.
// Depends on fcw_pkg, fcw_ctrl and fcw_datapath.
module fat12_cluster_chain_walker_core #(
    parameter int TABLE_ENTRIES = fcw_pkg::TABLE_ENTRIES
) (
    input  wire                      i_clk,
    input  wire                      i_rst_n,
    // input beats: table byte writes and walk requests
    input  wire                      i_in_valid,
    output logic                     o_in_ready,
    input  wire fcw_pkg::t_in_item   i_in,
    // result beats, one per input beat
    output logic                     o_out_valid,
    input  wire                      i_out_ready,
    output fcw_pkg::t_out_item       o_out
);

    // Commands from the sequencer to the datapath, and status back.
    fcw_pkg::t_dp_cmd  cmd;
    fcw_pkg::t_dp_stat stat;

    // Sequencer: idle/accept, then per hop check cluster and read low byte,
    // read high byte, classify entry. The result register is free whenever a
    // walk finishes, since acceptance needs the previous result taken or going.
    fcw_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    // Datapath: byte store of TABLE_ENTRIES*3/2 bytes, current cluster and
    // remaining hop registers, nibble unpack of the 12-bit entry, result beat.
    fcw_datapath #(
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) u_dp (
        .i_clk  (i_clk),
        .i_in   (i_in),
        .i_cmd  (cmd),
        .o_stat (stat),
        .o_out  (o_out)
    );

endmodule

`default_nettype wire

// ===== rtl/fcw_checker.sv =====
// Port-level checks for the FAT12 cluster chain walker, bound to the top level.
// Depends on fcw_pkg and fat12_cluster_chain_walker_core.
`default_nettype none

module fcw_checker (
    input wire                     i_clk,
    input wire                     i_rst_n,
    input wire                     i_in_valid,
    input wire                     o_in_ready,
    input wire fcw_pkg::t_in_item  i_in,
    input wire                     o_out_valid,
    input wire                     i_out_ready,
    input wire fcw_pkg::t_out_item o_out
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out))
        else $error("result beat dropped or changed while stalled");

    a_write_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready && !i_in.cmd |=>
            o_out_valid && o_out.status == fcw_pkg::ST_OK && o_out.cluster == '0)
        else $error("write beat did not give an ok result next cycle");

    a_zero_hop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready && i_in.cmd && i_in.hop_count == '0 |=>
            o_out_valid && o_out.status == fcw_pkg::ST_OK
            && o_out.cluster == $past(i_in.first_cluster))
        else $error("zero-hop walk did not return its first cluster");

    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out.status != fcw_pkg::ST_OK |->
            o_out.cluster == '0
            && (o_out.status == fcw_pkg::ST_END || o_out.status == fcw_pkg::ST_BAD))
        else $error("failed walk carries a cluster or an unknown status");

endmodule

bind fat12_cluster_chain_walker_core fcw_checker u_fcw_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .i_in        (i_in),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out       (o_out)
);

`default_nettype wire
